@@ design/mmfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfe_pkg
// shared widths, constants and the cordic angle table
// ----------------------------------------------------------------------------
package mmfe_pkg;
   localparam int AngleWidth  = 17;
   localparam int WordWidth   = 32;
   localparam int RotBits     = 30;
   localparam int CordicSteps = 16;
   localparam int FullTurn    = 46080;
   localparam int HalfTurn    = 23040;
   localparam int QuarterTurn = 11520;
   localparam int CordicWidth = 34;
   localparam int ZWidth      = 26;
   localparam int ReqBits     = 3 * AngleWidth + 6 * WordWidth;
   localparam int ReqBytes    = (ReqBits + 7) / 8;
   localparam int RspBytes    = (12 * WordWidth) / 8;
   localparam logic signed [CordicWidth-1:0] GainInv = 34'sd652032874;

   typedef logic signed [CordicWidth-1:0] rot_type;
   typedef logic signed [WordWidth-1:0]   word_type;

   function automatic logic signed [ZWidth-1:0] atan_step(input logic [3:0] idx);
      logic signed [ZWidth-1:0] v;
      case (idx)
         4'd0:  v = 26'sd2949120;
         4'd1:  v = 26'sd1740967;
         4'd2:  v = 26'sd919879;
         4'd3:  v = 26'sd466945;
         4'd4:  v = 26'sd234379;
         4'd5:  v = 26'sd117304;
         4'd6:  v = 26'sd58666;
         4'd7:  v = 26'sd29335;
         4'd8:  v = 26'sd14668;
         4'd9:  v = 26'sd7334;
         4'd10: v = 26'sd3667;
         4'd11: v = 26'sd1833;
         4'd12: v = 26'sd917;
         4'd13: v = 26'sd458;
         4'd14: v = 26'sd229;
         default: v = 26'sd115;
      endcase
      return v;
   endfunction

   // q30 product rounded to nearest, 68-bit full width
   function automatic rot_type qmul(input rot_type a, input rot_type b);
      logic signed [2*CordicWidth-1:0] p;
      p = a * b + (68'sd1 <<< (RotBits - 1));
      return rot_type'(p >>> RotBits);
   endfunction
endpackage

@@ design/model_matrix_from_euler_scale_shift_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// model_matrix_from_euler_scale_shift_unit
// builds the top three rows of T*Rx*Ry*Rz*S from angles, shift and scale
// ----------------------------------------------------------------------------
// Accepts one request per clock while the pipe advances, and returns one matrix per request in order.
// The pipe is 22 register stages deep: one for angle reduction, sixteen cordic
// stages, two product stages for the rotation entries, two for the scale
// multiply and rounding, and one output register that also saturates.
// The whole pipe advances whenever the output register is empty or being
// taken, so back-pressure holds every stage, bubbles included.
module model_matrix_from_euler_scale_shift_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // angle_x, angle_y, angle_z, shift_x..z, scale_x..z, zero fill
   input  logic [mmfe_pkg::ReqBytes*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // m_r0_c0..m_r0_c3, m_r1_c0..m_r1_c3, m_r2_c0..m_r2_c3
   output logic [mmfe_pkg::RspBytes*8-1:0] rsp_tdata
);
   import mmfe_pkg::*;

   localparam int Stages = CordicSteps + 6;

   logic adv;
   logic [Stages-1:0] vld_ff, vld_in;

   // pipeline moves whenever the output slot frees up
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[Stages-1];

   always_comb begin
      vld_in = {vld_ff[Stages-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // side data carried with the angles
   word_type sh_ff [0:Stages-1][0:2];
   word_type sc_ff [0:Stages-1][0:2];

   // reduced cordic state per axis
   rot_type x_ff [0:CordicSteps][0:2];
   rot_type y_ff [0:CordicSteps][0:2];
   logic signed [ZWidth-1:0] z_ff [0:CordicSteps][0:2];
   logic neg_ff [0:CordicSteps][0:2];

   // angle reduction into quarter turn
   always_ff @(posedge clock) begin
      logic signed [AngleWidth:0] a;
      logic signed [AngleWidth+1:0] r;
      logic flip;
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            a = (AngleWidth+1)'($signed(req_tdata[k*AngleWidth +: AngleWidth]));
            r = (AngleWidth+2)'(a);
            if (r < 0) r = r + (AngleWidth+2)'(FullTurn);
            if (r < 0) r = r + (AngleWidth+2)'(FullTurn);
            if (r >= (AngleWidth+2)'(FullTurn)) r = r - (AngleWidth+2)'(FullTurn);
            if (r > (AngleWidth+2)'(HalfTurn)) r = r - (AngleWidth+2)'(FullTurn);
            flip = 1'b0;
            if (r > (AngleWidth+2)'(QuarterTurn)) begin
               r = r - (AngleWidth+2)'(HalfTurn);
               flip = 1'b1;
            end else if (r < -(AngleWidth+2)'(QuarterTurn)) begin
               r = r + (AngleWidth+2)'(HalfTurn);
               flip = 1'b1;
            end
            neg_ff[0][k] <= flip;
            z_ff[0][k] <= ZWidth'(r) <<< 9;
            x_ff[0][k] <= GainInv;
            y_ff[0][k] <= '0;
            sh_ff[0][k] <= req_tdata[3*AngleWidth + k*WordWidth +: WordWidth];
            sc_ff[0][k] <= req_tdata[3*AngleWidth + (3+k)*WordWidth +: WordWidth];
         end
      end
   end

   // cordic rotation stages
   for (genvar s = 0; s < CordicSteps; s++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < 3; k++) begin
               if (z_ff[s][k] >= 0) begin
                  x_ff[s+1][k] <= x_ff[s][k] - (y_ff[s][k] >>> s);
                  y_ff[s+1][k] <= y_ff[s][k] + (x_ff[s][k] >>> s);
                  z_ff[s+1][k] <= z_ff[s][k] - atan_step(4'(s));
               end else begin
                  x_ff[s+1][k] <= x_ff[s][k] + (y_ff[s][k] >>> s);
                  y_ff[s+1][k] <= y_ff[s][k] - (x_ff[s][k] >>> s);
                  z_ff[s+1][k] <= z_ff[s][k] + atan_step(4'(s));
               end
               neg_ff[s+1][k] <= neg_ff[s][k];
            end
         end
      end
   end

   for (genvar s = 1; s < Stages; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (adv) begin
            sh_ff[s] <= sh_ff[s-1];
            sc_ff[s] <= sc_ff[s-1];
         end
      end
   end

   // first product stage: sin/cos and pair products
   rot_type sn [0:2], cs [0:2];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sn[k] = neg_ff[CordicSteps][k] ? -y_ff[CordicSteps][k] : y_ff[CordicSteps][k];
         cs[k] = neg_ff[CordicSteps][k] ? -x_ff[CordicSteps][k] : x_ff[CordicSteps][k];
      end
   end

   rot_type sxsy_ff, cxsy_ff, cycz_ff, cysz_ff, sy_ff, sxcy_ff, sxsz_ff, cxcz_ff;
   rot_type cxsz_ff, sxcz_ff, cxcy_ff, cz_ff, sz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sxsy_ff <= qmul(sn[0], sn[1]);
         cxsy_ff <= qmul(cs[0], sn[1]);
         cycz_ff <= qmul(cs[1], cs[2]);
         cysz_ff <= qmul(cs[1], sn[2]);
         sy_ff   <= sn[1];
         sxcy_ff <= qmul(sn[0], cs[1]);
         sxsz_ff <= qmul(sn[0], sn[2]);
         cxcz_ff <= qmul(cs[0], cs[2]);
         cxsz_ff <= qmul(cs[0], sn[2]);
         sxcz_ff <= qmul(sn[0], cs[2]);
         cxcy_ff <= qmul(cs[0], cs[1]);
         cz_ff   <= cs[2];
         sz_ff   <= sn[2];
      end
   end

   // second product stage: rotation entries
   rot_type r_ff [0:2][0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0][0] <= cycz_ff;
         r_ff[0][1] <= -cysz_ff;
         r_ff[0][2] <= sy_ff;
         r_ff[1][0] <= qmul(sxsy_ff, cz_ff) + cxsz_ff;
         r_ff[1][1] <= cxcz_ff - qmul(sxsy_ff, sz_ff);
         r_ff[1][2] <= -sxcy_ff;
         r_ff[2][0] <= sxsz_ff - qmul(cxsy_ff, cz_ff);
         r_ff[2][1] <= qmul(cxsy_ff, sz_ff) + sxcz_ff;
         r_ff[2][2] <= cxcy_ff;
      end
   end

   // scale multiply, then rounding
   logic signed [2*CordicWidth-1:0] p_ff [0:2][0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[i][j] <= r_ff[i][j] * CordicWidth'(sc_ff[CordicSteps+2][j]);
            end
         end
      end
   end

   logic signed [2*CordicWidth-1:0] q_ff [0:2][0:2];
   always_ff @(posedge clock) begin
      logic signed [2*CordicWidth-1:0] t;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               t = (p_ff[i][j] + (68'sd1 <<< (RotBits - 1))) >>> RotBits;
               q_ff[i][j] <= t;
            end
         end
      end
   end

   // output register with saturation
   logic [RspBytes*8-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (q_ff[i][j] > 68'sd2147483647)
                  out_ff[(i*4+j)*WordWidth +: WordWidth] <= 32'h7fffffff;
               else if (q_ff[i][j] < -68'sd2147483648)
                  out_ff[(i*4+j)*WordWidth +: WordWidth] <= 32'h80000000;
               else
                  out_ff[(i*4+j)*WordWidth +: WordWidth] <= WordWidth'(q_ff[i][j]);
            end
            out_ff[(i*4+3)*WordWidth +: WordWidth] <= sh_ff[Stages-2][i];
         end
      end
   end
   assign rsp_tdata = out_ff;

   // output stays put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // a taken request shows up in the first valid stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("request lost at entry");
   // stall freezes the valid chain
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
endmodule

@@ tb/sv/mmfe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfe_checker
// watches the request and response streams and checks every model matrix
// ----------------------------------------------------------------------------
// Each accepted request is run through a bit-true model of the angle
// reduction, cordic, rotation products and saturated scaling; the resulting
// matrix is queued and compared field by field with the next response.
module mmfe_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [mmfe_pkg::ReqBytes*8-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [mmfe_pkg::RspBytes*8-1:0]  rsp_tdata,
   output int                               fail_count,
   output int                               pending
);
   import mmfe_pkg::*;

   typedef logic [RspBytes*8-1:0] matrix_bits;

   matrix_bits matrix_queue[$];

   // atan(2^-i) in 2^-16 degree units
   function automatic longint atan_deg(input int i);
      longint tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
         58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      return tab[i];
   endfunction

   function automatic longint round_q30(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // sine and cosine in q30 of an angle in 1/128 degree
   function automatic void trig(input logic signed [16:0] ang,
                                output longint s, output longint c);
      longint r, x, y, z, nx;
      bit flip;
      r = longint'(ang) % FullTurn;
      flip = 0;
      if (r < 0) r += FullTurn;
      if (r > HalfTurn) r -= FullTurn;
      if (r > QuarterTurn) begin
         r -= HalfTurn;
         flip = 1;
      end else if (r < -QuarterTurn) begin
         r += HalfTurn;
         flip = 1;
      end
      x = 652032874;
      y = 0;
      z = r * 512;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_deg(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_deg(i);
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic logic [31:0] sat_scale(input longint rot, input longint scl);
      longint v;
      v = round_q30(rot, scl);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic matrix_bits build_matrix(input logic [ReqBytes*8-1:0] d);
      longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
      longint rot[3][3];
      longint scl[3];
      matrix_bits m;
      trig(d[16:0], sx, cx);
      trig(d[33:17], sy, cy);
      trig(d[50:34], sz, cz);
      for (int j = 0; j < 3; j++)
         scl[j] = longint'($signed(d[147 + 32*j +: 32]));
      sxsy = round_q30(sx, sy);
      cxsy = round_q30(cx, sy);
      rot[0][0] = round_q30(cy, cz);
      rot[0][1] = -round_q30(cy, sz);
      rot[0][2] = sy;
      rot[1][0] = round_q30(sxsy, cz) + round_q30(cx, sz);
      rot[1][1] = round_q30(cx, cz) - round_q30(sxsy, sz);
      rot[1][2] = -round_q30(sx, cy);
      rot[2][0] = round_q30(sx, sz) - round_q30(cxsy, cz);
      rot[2][1] = round_q30(cxsy, sz) + round_q30(sx, cz);
      rot[2][2] = round_q30(cx, cy);
      m = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++)
            m[(i*4 + j)*32 +: 32] = sat_scale(rot[i][j], scl[j]);
         m[(i*4 + 3)*32 +: 32] = d[51 + 32*i +: 32];
      end
      return m;
   endfunction

   // predict on request, compare on response
   always @(posedge clock) begin
      matrix_bits want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            matrix_queue = {matrix_queue, build_matrix(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            if (matrix_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = matrix_queue.pop_front();
               for (int f = 0; f < 12; f++) begin
                  if (rsp_tdata[f*32 +: 32] !== want[f*32 +: 32]) begin
                     if (fail_count < 10)
                        $display("entry r%0d c%0d: expected %h actual %h",
                           f / 4, f % 4, want[f*32 +: 32], rsp_tdata[f*32 +: 32]);
                     fail_count <= fail_count + 1;
                     break;
                  end
               end
            end
         end
      end
      pending = matrix_queue.size();
   end
endmodule

@@ tb/sv/model_matrix_from_euler_scale_shift_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// model_matrix_from_euler_scale_shift_unit_tb
// drives euler angle, shift and scale requests and gives the verdict
// ----------------------------------------------------------------------------
// Directed corner requests come first, then random ones with random gaps and
// response stalls, one long response hold-off and one drain pause.
module model_matrix_from_euler_scale_shift_unit_tb;
   import mmfe_pkg::*;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [ReqBytes*8-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RspBytes*8-1:0] rsp_tdata;
   int   fail_count;
   int   pending;
   bit   long_hold;
   bit   stim_done;

   model_matrix_from_euler_scale_shift_unit DUT (.*);

   mmfe_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("model_matrix_from_euler_scale_shift_unit_tb failed");
      $finish;
   end

   // build a request: angles, shift, scale
   function automatic logic [ReqBytes*8-1:0] pack_request(
      input logic [16:0] ax, ay, az, input logic [31:0] tx, ty, tz, kx, ky, kz);
      logic [ReqBytes*8-1:0] d;
      d = '0;
      d[16:0] = ax;
      d[33:17] = ay;
      d[50:34] = az;
      d[82:51] = tx;
      d[114:83] = ty;
      d[146:115] = tz;
      d[178:147] = kx;
      d[210:179] = ky;
      d[242:211] = kz;
      return d;
   endfunction

   function automatic logic [16:0] rand_angle();
      case ($urandom_range(0, 4))
         0: return 17'($urandom);
         1: return 17'($signed(-46080 + $urandom_range(0, 4) * 11520));
         default: return 17'($signed($urandom_range(0, 92160)) - 46080);
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   // gap first, then offer and hold until taken; valid stays up at return
   task automatic send_request(input logic [ReqBytes*8-1:0] d);
      int idle;
      idle = $urandom_range(0, 6);
      if (idle > 0) begin
         req_tvalid <= 0;
         repeat (idle) @(negedge clock);
      end
      req_tdata <= d;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // back-to-back offers for the stall phase
   task automatic burst_requests(input int n);
      for (int k = 0; k < n; k++) begin
         req_tdata <= pack_request(rand_angle(), rand_angle(), rand_angle(),
            rand_word(), rand_word(), rand_word(),
            rand_word(), rand_word(), rand_word());
         req_tvalid <= 1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         @(negedge clock);
      end
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (200) @(negedge clock);
            long_hold = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   initial begin
      logic [16:0] edge_angles[10] = '{17'h10000, 17'h0ffff,
         17'($signed(-46080)), 17'd46080, 17'd23040, 17'($signed(-23040)),
         17'd11520, 17'($signed(-11520)), 17'd0, 17'd11521};
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      long_hold = 0;
      stim_done = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed corners: angle extremes, quarter turns, scale saturation
      for (int k = 0; k < 10; k++)
         send_request(pack_request(edge_angles[k], edge_angles[9-k],
            edge_angles[(k+3)%10], 32'h7fffffff, 32'h80000000, 32'h00010000,
            32'h00010000, 32'hffff0000, 32'h00020000));
      send_request(pack_request(17'd0, 17'd0, 17'd0, '0, '0, '0, '0, '0, '0));
      send_request(pack_request(17'd23040, 17'd23040, 17'd23040,
         32'hffffffff, 32'hffffffff, 32'hffffffff,
         32'h80000000, 32'h80000000, 32'h80000000));
      send_request(pack_request(17'h1ffff, 17'h1ffff, 17'h1ffff,
         32'h55555555, 32'haaaaaaaa, 32'h0,
         32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_request(pack_request(17'($signed(-23040)), 17'd11520, 17'd3000,
         32'h1, 32'h2, 32'h3, 32'h80000000, 32'h7fffffff, 32'h80000001));

      // fill the pipe while the response side holds off
      long_hold = 1;
      burst_requests(60);

      for (int k = 0; k < 330; k++) begin
         // one pause until everything has drained
         if (k == 150) begin
            req_tvalid <= 0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         send_request(pack_request(rand_angle(), rand_angle(), rand_angle(),
            rand_word(), rand_word(), rand_word(),
            rand_word(), rand_word(), rand_word()));
      end
      req_tvalid <= 0;
      @(negedge clock);

      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("model_matrix_from_euler_scale_shift_unit_tb passed");
      else
         $display("model_matrix_from_euler_scale_shift_unit_tb failed");
      $finish;
   end
endmodule
